FILE: rtl/tsin_pkg.sv
// ----------------------------------------------------------------------------
// tsin_pkg
// Shared types, constants and the reciprocal factorial-step table.
// ----------------------------------------------------------------------------
package tsin_pkg;

  localparam int LANES       = 4;
  localparam int MAX_TERMS   = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [31:0] angle_lane0;
    logic signed [31:0] angle_lane1;
    logic signed [31:0] angle_lane2;
    logic signed [31:0] angle_lane3;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sine_lane0;
    logic signed [31:0] sine_lane1;
    logic signed [31:0] sine_lane2;
    logic signed [31:0] sine_lane3;
    logic [3:0]         saturated_mask;
  } out_item_t;

  // classified item: raw angles plus exact squares of their magnitudes
  typedef struct packed {
    logic [LANES-1:0][31:0] angle;
    logic [LANES-1:0][63:0] x2;
  } q_item_t;

  // per-lane series state: x^2 Q8.56, |term| Q.52, term sign, sum Q11.52
  typedef struct packed {
    logic [63:0] x2;
    logic [63:0] tmag;
    logic        tneg;
    logic [63:0] acc;
  } lane_t;

  // round(2^32 / ((2k)(2k+1))), k = idx + 1
  function automatic logic [31:0] recip(input logic [3:0] idx);
    logic [31:0] r;
    case (idx)
      4'd0:    r = 32'd715827883;
      4'd1:    r = 32'd214748365;
      4'd2:    r = 32'd102261126;
      4'd3:    r = 32'd59652324;
      4'd4:    r = 32'd39045157;
      4'd5:    r = 32'd27531842;
      4'd6:    r = 32'd20452225;
      4'd7:    r = 32'd15790321;
      4'd8:    r = 32'd12558384;
      4'd9:    r = 32'd10226113;
      4'd10:   r = 32'd8488078;
      4'd11:   r = 32'd7158279;
      4'd12:   r = 32'd6118187;
      4'd13:   r = 32'd5289369;
      4'd14:   r = 32'd4618244;
      4'd15:   r = 32'd4067204;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/tsin_chan_if.sv
// ----------------------------------------------------------------------------
// tsin_chan_if
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface tsin_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/taylor_sine_4lane.sv
// ----------------------------------------------------------------------------
// taylor_sine_4lane
// Four-lane Q3.28 sine by truncated Taylor series, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one request of four angles per cycle and returns one result per
// cycle while the output side is ready. Each series term is a four-stage
// slice (factor multiply, round, term multiply, accumulate). An accepted
// request passes the front register, which writes the queue, then one load
// stage, the term slices and the output register. A four-entry queue
// decouples the front from the term pipeline, which stalls as a whole when
// the output is held. Results out of Q3.28 range saturate and set the lane's
// bit in saturated_mask.
module taylor_sine_4lane #(
  parameter int TERM_COUNT = 12
) (
  input logic         clk,
  input logic         rst,
  tsin_chan_if.sink   in_ch,
  tsin_chan_if.source out_ch
);
  import tsin_pkg::*;

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  q_item_t push_item;
  q_item_t head;

  tsin_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  tsin_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tsin_back #(.TERM_COUNT(TERM_COUNT)) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule

FILE: rtl/tsin_front.sv
// ----------------------------------------------------------------------------
// tsin_front
// Accepts requests, takes angle magnitudes and squares them.
// ----------------------------------------------------------------------------
module tsin_front (
  input  logic              clk,
  input  logic              rst,
  tsin_chan_if.sink         in_ch,
  input  logic              q_full,
  output logic              push,
  output tsin_pkg::q_item_t push_item
);
  import tsin_pkg::*;

  logic                   f_vld;
  q_item_t                f_item;
  logic [LANES-1:0][31:0] ang;
  logic [LANES-1:0][31:0] mag;

  assign ang = {in_ch.data.angle_lane0, in_ch.data.angle_lane1,
                in_ch.data.angle_lane2, in_ch.data.angle_lane3};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = ang[l][31] ? (32'd0 - ang[l]) : ang[l];
    end
  end

  assign in_ch.ready = !f_vld || !q_full;
  assign push        = f_vld && !q_full;
  assign push_item   = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (in_ch.ready) begin
      f_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      for (int l = 0; l < LANES; l++) begin
        f_item.angle[l] <= ang[l];
        f_item.x2[l]    <= mag[l] * mag[l];
      end
    end
  end
endmodule

FILE: rtl/tsin_queue.sv
// ----------------------------------------------------------------------------
// tsin_queue
// Short FIFO between the front and the series pipeline.
// ----------------------------------------------------------------------------
module tsin_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsin_pkg::q_item_t push_item,
  input  logic              pop,
  output tsin_pkg::q_item_t head,
  output logic              full,
  output logic              empty
);
  import tsin_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  q_item_t           mem [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow");
`endif
endmodule

FILE: rtl/tsin_term.sv
// ----------------------------------------------------------------------------
// tsin_term
// One series term for one lane: f = x^2*recip, |t| *= f, sum +/-= |t|.
// ----------------------------------------------------------------------------
module tsin_term #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            en,
  input  tsin_pkg::lane_t lane_in,
  output tsin_pkg::lane_t lane_out
);
  import tsin_pkg::*;

  localparam logic [31:0] RECIP = recip(4'(IDX));

  lane_t        sa;
  lane_t        sb;
  lane_t        sc;
  logic [63:0]  fp0;
  logic [63:0]  fp1;
  logic [63:0]  f;
  logic [63:0]  q00;
  logic [63:0]  q01;
  logic [63:0]  q10;
  logic [63:0]  q11;
  logic [95:0]  fsum;
  logic [127:0] psum;
  logic [63:0]  tnew;

  always_comb begin
    fsum = {32'd0, fp0} + {fp1, 32'd0} + 96'h8000_0000;
    psum = {64'd0, q00} + {32'd0, q01, 32'd0} + {32'd0, q10, 32'd0}
         + {q11, 64'd0} + (128'd1 << 55);
    tnew = psum[119:56];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa  <= lane_in;
      fp0 <= lane_in.x2[31:0] * RECIP;
      fp1 <= lane_in.x2[63:32] * RECIP;
      sb  <= sa;
      f   <= fsum[95:32];
      sc  <= sb;
      q00 <= sb.tmag[31:0] * f[31:0];
      q01 <= sb.tmag[31:0] * f[63:32];
      q10 <= sb.tmag[63:32] * f[31:0];
      q11 <= sb.tmag[63:32] * f[63:32];
      lane_out.x2   <= sc.x2;
      lane_out.tmag <= tnew;
      lane_out.tneg <= !sc.tneg;
      lane_out.acc  <= sc.tneg ? (sc.acc + tnew) : (sc.acc - tnew);
    end
  end
endmodule

FILE: rtl/tsin_back.sv
// ----------------------------------------------------------------------------
// tsin_back
// Series pipeline: loads lanes from the queue, runs all terms, rounds,
// saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module tsin_back #(
  parameter int TERM_COUNT = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  tsin_pkg::q_item_t head,
  input  logic              empty,
  output logic              pop,
  tsin_chan_if.source       out_ch
);
  import tsin_pkg::*;

  localparam int TERMS = (TERM_COUNT > MAX_TERMS) ? MAX_TERMS : TERM_COUNT;
  localparam int DEPTH = 4 * TERMS;

  logic                   adv;
  logic                   e_vld;
  logic [DEPTH-1:0]       vsr;
  lane_t                  chain [TERMS+1][LANES];
  logic                   o_vld;
  out_item_t              o_data;
  logic [LANES-1:0][31:0] res;
  logic [LANES-1:0]       sat;
  logic [63:0]            rnd  [LANES];
  logic [39:0]            r40  [LANES];
  logic [31:0]            mag  [LANES];

  assign adv = !o_vld || out_ch.ready;
  assign pop = adv && !empty;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = head.angle[l][31] ? (32'd0 - head.angle[l]) : head.angle[l];
      rnd[l] = chain[TERMS][l].acc + 64'h80_0000;
      r40[l] = rnd[l][63:24];
      sat[l] = (r40[l][39:31] != '0) && (r40[l][39:31] != '1);
      res[l] = sat[l] ? (r40[l][39] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r40[l][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
      vsr   <= '0;
      o_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= !empty;
      vsr   <= {vsr[DEPTH-2:0], e_vld};
      o_vld <= vsr[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        chain[0][l].x2   <= head.x2[l];
        chain[0][l].tmag <= {8'd0, mag[l], 24'd0};
        chain[0][l].tneg <= head.angle[l][31];
        chain[0][l].acc  <= {{8{head.angle[l][31]}}, head.angle[l], 24'd0};
      end
      o_data.sine_lane0     <= res[3];
      o_data.sine_lane1     <= res[2];
      o_data.sine_lane2     <= res[1];
      o_data.sine_lane3     <= res[0];
      o_data.saturated_mask <= {sat[0], sat[1], sat[2], sat[3]};
    end
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      tsin_term #(.IDX(k)) u_term (
        .clk      (clk),
        .en       (adv),
        .lane_in  (chain[k][l]),
        .lane_out (chain[k+1][l])
      );
    end
  end

  assign out_ch.valid = o_vld;
  assign out_ch.data  = o_data;
endmodule

FILE: tb/sv/taylor_sine_4lane_tb.sv
// ----------------------------------------------------------------------------
// taylor_sine_4lane_tb
// Drives random and directed angle requests into the four-lane sine block
// and checks every result against a bit-exact fixed-point series predictor.
// ----------------------------------------------------------------------------
module taylor_sine_4lane_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsin_pkg::*;

  localparam int TERMS   = 12;
  localparam int LATENCY = 4 * TERMS + 4;
  localparam int N_RAND  = 1700;

  // round(2^32 / ((2k)(2k+1))), k = index + 1
  localparam logic [31:0] STEP_RECIP [16] = '{
    32'd715827883, 32'd214748365, 32'd102261126, 32'd59652324,
    32'd39045157,  32'd27531842,  32'd20452225,  32'd15790321,
    32'd12558384,  32'd10226113,  32'd8488078,   32'd7158279,
    32'd6118187,   32'd5289369,   32'd4618244,   32'd4067204};

  function automatic logic [63:0] mul_rnd(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (sh - 1));
    p = p >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [32:0] sine_of(logic [31:0] x);
    logic        neg, tneg;
    logic [63:0] mag, x2, acc, tmag, f, q;
    logic [63:0] base;
    int          nt;
    neg  = x[31];
    mag  = neg ? (64'd1 << 32) - {32'd0, x} : {32'd0, x};
    x2   = mag * mag;
    acc  = {{32{x[31]}}, x} << 24;
    tmag = mag << 24;
    tneg = neg;
    base = 64'd1 << 39;
    nt   = TERMS > 16 ? 16 : TERMS;
    for (int k = 0; k < nt; k++) begin
      f    = mul_rnd(x2, {32'd0, STEP_RECIP[k]}, 32);
      tmag = mul_rnd(tmag, f, 56);
      tneg = !tneg;
      acc  = tneg ? acc - tmag : acc + tmag;
    end
    q = (acc + (64'd1 << 63) + (64'd1 << 23)) >> 24;
    if (q > base + 64'h7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
    if (q < base - 64'h80000000) return {1'b1, 32'h80000000};
    return {1'b0, 32'(q - base)};
  endfunction

  class sine_scoreboard;
    out_item_t pending[$];
    int        errors = 0;

    function void note_request(in_item_t r);
      out_item_t e;
      logic [32:0] l0, l1, l2, l3;
      l0 = sine_of(r.angle_lane0);
      l1 = sine_of(r.angle_lane1);
      l2 = sine_of(r.angle_lane2);
      l3 = sine_of(r.angle_lane3);
      e.sine_lane0 = l0[31:0];
      e.sine_lane1 = l1[31:0];
      e.sine_lane2 = l2[31:0];
      e.sine_lane3 = l3[31:0];
      e.saturated_mask = {l3[32], l2[32], l1[32], l0[32]};
      pending.push_back(e);
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.sine_lane0 !== e.sine_lane0) begin
        $display("%0t: sine_lane0 exp %h got %h", $time, e.sine_lane0, a.sine_lane0);
        errors++;
      end
      if (a.sine_lane1 !== e.sine_lane1) begin
        $display("%0t: sine_lane1 exp %h got %h", $time, e.sine_lane1, a.sine_lane1);
        errors++;
      end
      if (a.sine_lane2 !== e.sine_lane2) begin
        $display("%0t: sine_lane2 exp %h got %h", $time, e.sine_lane2, a.sine_lane2);
        errors++;
      end
      if (a.sine_lane3 !== e.sine_lane3) begin
        $display("%0t: sine_lane3 exp %h got %h", $time, e.sine_lane3, a.sine_lane3);
        errors++;
      end
      if (a.saturated_mask !== e.saturated_mask) begin
        $display("%0t: saturated_mask exp %h got %h", $time, e.saturated_mask,
                 a.saturated_mask);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;

  tsin_chan_if #(.payload_t(in_item_t))  in_ch ();
  tsin_chan_if #(.payload_t(out_item_t)) out_ch ();

  taylor_sine_4lane #(.TERM_COUNT(TERMS)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  sine_scoreboard sb = new();

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 24);
        out_ch.ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1686629713)));
      2: return -32'($signed($urandom_range(0, 1686629713)));
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      4: return {{2{$urandom_range(0, 1) == 1}}, 30'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                           : 32'h80000000 + $urandom_range(0, 255);
    endcase
  endfunction

  task automatic send_request(in_item_t r);
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_burst();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  initial begin
    static logic [31:0] edges [12] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF,
                                       32'h80000000, 32'h80000001, 32'h1921FB54,
                                       32'hE6DE04AC, 32'h3243F6A9, 32'h6487ED51,
                                       32'h9B7812AF, 32'h10000000};
    in_item_t r;
    int guard;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 12; i++) begin
      r = {edges[i], edges[(i + 3) % 12], edges[(i + 6) % 12], edges[(i + 9) % 12]};
      send_request(r);
      idle_burst();
    end
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND - 200) calm = 1'b1;
      r = {pick_angle(), pick_angle(), pick_angle(), pick_angle()};
      send_request(r);
      idle_burst();
    end
    in_ch.valid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
